// ===== rtl/core/bxds_pkg.sv =====
// Shared constants, command and status types for the RGBA8 box downscaler.
`default_nettype none

package bxds_pkg;

    localparam int unsigned MAX_SRC_DIM = 1024;
    localparam int unsigned MAX_DST_DIM = 256;
    localparam int unsigned MAX_ENLARGE = 8;

    localparam int unsigned SRC_DIM_W   = 11;
    localparam int unsigned DST_DIM_W   = 9;
    localparam int unsigned CFG_DATA_W  = 11;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned POS_W       = 10;
    localparam int unsigned XADDR_W     = $clog2(MAX_DST_DIM);
    localparam int unsigned COORD_W     = 8;
    localparam int unsigned NUM_W       = 20;
    localparam int unsigned SUM_W       = 28;
    localparam int unsigned CNT_W       = 21;
    localparam int unsigned Q_W         = 11;
    localparam int unsigned CH_N        = 4;
    localparam int unsigned CH_W        = 8;
    localparam int unsigned PIX_W       = CH_N * CH_W;
    localparam int unsigned OUT_TDATA_W = 2 * COORD_W + PIX_W;
    localparam int unsigned ENL_W       = SRC_DIM_W + $clog2(MAX_ENLARGE);

    typedef logic [CH_N-1:0][SUM_W-1:0] sums_t;
    typedef logic [CH_N-1:0][Q_W-1:0]   quots_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_DST_WIDTH,
        REG_DST_HEIGHT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIV_SRC_X,
        DIV_SRC_Y,
        DIV_SRC_CH
    } div_src_t;

    typedef struct packed {
        logic     accept;
        logic     err_load;
        logic     y_init;
        logic     y_hload;
        logic     y_adv;
        logic     x_init;
        logic     x_hload;
        logic     x_adv;
        logic     div_start;
        div_src_t div_src;
        logic     rd_x;
        logic     wr_acc;
        logic     emit_init;
        logic     rd_e;
        logic     out_load;
        logic     e_next_x;
        logic     e_next_y;
        logic     pos_adv;
    } bxds_cmd_t;

    typedef struct packed {
        logic sc_zero;
        logic sr_zero;
        logic cfg_bad;
        logic y_in;
        logic y_done;
        logic x_in;
        logic x_done;
        logic emit_go;
        logic e_xlast;
        logic e_ylast;
        logic div_done;
        logic out_free;
    } bxds_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bxds_div.sv =====
// Four-lane restoring divider with a shared divisor, one quotient bit per cycle.
`default_nettype none

module bxds_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire bxds_pkg::sums_t              num,
    input  wire logic [bxds_pkg::CNT_W-1:0]   den,
    output logic                              done,
    output bxds_pkg::quots_t                  quo
);

    localparam int unsigned STEP_W  = $clog2(bxds_pkg::Q_W);
    localparam int unsigned TRIAL_W = bxds_pkg::CNT_W + bxds_pkg::Q_W;

    bxds_pkg::sums_t                rem_reg, rem_next;
    bxds_pkg::quots_t               quo_reg, quo_next;
    logic [bxds_pkg::CNT_W-1:0]     den_reg;
    logic [STEP_W-1:0]              step_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [TRIAL_W-1:0]             shifted;

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        shifted  = TRIAL_W'(den_reg) << step_reg;
        for (int c = 0; c < bxds_pkg::CH_N; c++) begin
            if (TRIAL_W'(rem_reg[c]) >= shifted) begin
                rem_next[c]           = bxds_pkg::SUM_W'(TRIAL_W'(rem_reg[c]) - shifted);
                quo_next[c][step_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(bxds_pkg::Q_W - 1);
        end else if (busy_reg) begin
            if (step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            quo_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bxds_ctrl.sv =====
// Sequencer that steps one source pixel through window tracking, accumulation and output.
`default_nettype none

module bxds_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire bxds_pkg::bxds_stat_t stat,
    output bxds_pkg::bxds_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_YINIT,
        ST_YDST,
        ST_YDIV,
        ST_YCHK,
        ST_XINIT,
        ST_XDST,
        ST_XDIV,
        ST_XCHK,
        ST_XACC,
        ST_EMIT,
        ST_ERD,
        ST_EDST,
        ST_EDIV,
        ST_EOUT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (stat.cfg_bad) begin
                        state_next = ST_ERR;
                    end else if (stat.sc_zero) begin
                        state_next = stat.sr_zero ? ST_YINIT : ST_YCHK;
                    end else begin
                        state_next = ST_XCHK;
                    end
                end
            end
            ST_ERR: begin
                if (stat.out_free) begin
                    cmd.err_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_YINIT: begin
                cmd.y_init = 1'b1;
                state_next = ST_YDST;
            end
            ST_YDST: begin
                cmd.div_start = 1'b1;
                cmd.div_src   = bxds_pkg::DIV_SRC_Y;
                state_next    = ST_YDIV;
            end
            ST_YDIV: begin
                if (stat.div_done) begin
                    cmd.y_hload = 1'b1;
                    state_next  = ST_YCHK;
                end
            end
            ST_YCHK: begin
                if (stat.y_in && stat.y_done) begin
                    cmd.y_adv  = 1'b1;
                    state_next = ST_YDST;
                end else begin
                    state_next = ST_XINIT;
                end
            end
            ST_XINIT: begin
                cmd.x_init = 1'b1;
                state_next = ST_XDST;
            end
            ST_XDST: begin
                cmd.div_start = 1'b1;
                cmd.div_src   = bxds_pkg::DIV_SRC_X;
                state_next    = ST_XDIV;
            end
            ST_XDIV: begin
                if (stat.div_done) begin
                    cmd.x_hload = 1'b1;
                    state_next  = ST_XCHK;
                end
            end
            ST_XCHK: begin
                if (stat.x_in) begin
                    cmd.rd_x   = 1'b1;
                    state_next = ST_XACC;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_XACC: begin
                cmd.wr_acc = 1'b1;
                if (stat.x_done) begin
                    cmd.x_adv  = 1'b1;
                    state_next = ST_XDST;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.emit_go) begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_ERD;
                end else begin
                    cmd.pos_adv = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_ERD: begin
                cmd.rd_e   = 1'b1;
                state_next = ST_EDST;
            end
            ST_EDST: begin
                cmd.div_start = 1'b1;
                cmd.div_src   = bxds_pkg::DIV_SRC_CH;
                state_next    = ST_EDIV;
            end
            ST_EDIV: begin
                if (stat.div_done) begin
                    state_next = ST_EOUT;
                end
            end
            ST_EOUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (!stat.e_xlast) begin
                        cmd.e_next_x = 1'b1;
                        state_next   = ST_ERD;
                    end else if (!stat.e_ylast) begin
                        cmd.e_next_y = 1'b1;
                        state_next   = ST_ERD;
                    end else begin
                        cmd.pos_adv = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bxds_dp.sv =====
// Datapath: configuration, window tracking, column sum memory, divider and output register.
`default_nettype none

module bxds_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [bxds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bxds_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic [bxds_pkg::PIX_W-1:0]          s_tdata,
    input  wire bxds_pkg::bxds_cmd_t                 cmd,
    output bxds_pkg::bxds_stat_t                     stat,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [bxds_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                     m_tlast,
    output logic                                     m_tuser
);

    localparam int unsigned SW = bxds_pkg::SRC_DIM_W;
    localparam int unsigned DW = bxds_pkg::DST_DIM_W;
    localparam int unsigned AW = bxds_pkg::XADDR_W;
    localparam int unsigned CW = bxds_pkg::COORD_W;

    logic [SW-1:0] sw_reg, sh_reg;
    logic [DW-1:0] dw_reg, dh_reg;
    logic [bxds_pkg::POS_W-1:0] sc_reg, sr_reg;

    logic [bxds_pkg::PIX_W-1:0] px_reg;

    logic [DW-1:0]              y_reg, x_reg;
    logic [SW-1:0]              ylo_reg, yhraw_reg, xlo_reg, xhraw_reg;
    logic [bxds_pkg::NUM_W-1:0] ynum_reg, xnum_reg;
    logic                       yany_reg, xany_reg;
    logic [CW-1:0]              yf_reg, yl_reg, xf_reg, xl_reg;
    logic [SW-1:0]              hy_reg, wx_reg;
    logic [bxds_pkg::CNT_W-1:0] cnt_reg;
    logic [CW-1:0]              ex_reg, ey_reg;

    logic [bxds_pkg::MAX_DST_DIM-1:0] vld_reg;
    bxds_pkg::sums_t                  sum_mem [bxds_pkg::MAX_DST_DIM];
    bxds_pkg::sums_t                  rd_reg;
    logic                             rdv_reg;

    logic                             m_valid_reg;
    logic [bxds_pkg::OUT_TDATA_W-1:0] m_data_reg;
    logic                             m_last_reg;
    logic                             m_err_reg;

    logic [SW-1:0]          yhi, xhi, sr_p1, sc_p1;
    bxds_pkg::sums_t        rd_sums, acc_sums, mem_wdata, div_num;
    logic [bxds_pkg::CNT_W-1:0] div_den;
    logic                   div_done;
    bxds_pkg::quots_t       div_quo;
    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [2*SW-1:0]        cnt_prod;
    logic [bxds_pkg::PIX_W-1:0] avg_pix;
    logic                   cfg_bad;

    assign sr_p1 = SW'(sr_reg) + SW'(1);
    assign sc_p1 = SW'(sc_reg) + SW'(1);
    assign yhi   = (yhraw_reg > ylo_reg) ? yhraw_reg : ylo_reg + SW'(1);
    assign xhi   = (xhraw_reg > xlo_reg) ? xhraw_reg : xlo_reg + SW'(1);

    assign cfg_bad = (sw_reg == '0) || (sw_reg > SW'(bxds_pkg::MAX_SRC_DIM))
                  || (sh_reg == '0) || (sh_reg > SW'(bxds_pkg::MAX_SRC_DIM))
                  || (dw_reg == '0) || (dw_reg > DW'(bxds_pkg::MAX_DST_DIM))
                  || (dh_reg == '0) || (dh_reg > DW'(bxds_pkg::MAX_DST_DIM))
                  || (bxds_pkg::ENL_W'(dw_reg) >
                      bxds_pkg::ENL_W'(sw_reg) * bxds_pkg::ENL_W'(bxds_pkg::MAX_ENLARGE))
                  || (bxds_pkg::ENL_W'(dh_reg) >
                      bxds_pkg::ENL_W'(sh_reg) * bxds_pkg::ENL_W'(bxds_pkg::MAX_ENLARGE));

    assign rd_sums = rdv_reg ? rd_reg : '0;

    always_comb begin
        for (int c = 0; c < bxds_pkg::CH_N; c++) begin
            acc_sums[c] = rd_sums[c]
                        + bxds_pkg::SUM_W'(px_reg[c*bxds_pkg::CH_W +: bxds_pkg::CH_W]);
            avg_pix[c*bxds_pkg::CH_W +: bxds_pkg::CH_W] = div_quo[c][bxds_pkg::CH_W-1:0];
        end
    end

    always_comb begin
        div_num = '0;
        div_den = '0;
        case (cmd.div_src)
            bxds_pkg::DIV_SRC_X: begin
                div_num[0] = bxds_pkg::SUM_W'(xnum_reg);
                div_den    = bxds_pkg::CNT_W'(dw_reg);
            end
            bxds_pkg::DIV_SRC_Y: begin
                div_num[0] = bxds_pkg::SUM_W'(ynum_reg);
                div_den    = bxds_pkg::CNT_W'(dh_reg);
            end
            bxds_pkg::DIV_SRC_CH: begin
                div_num = rd_sums;
                div_den = cnt_reg;
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    bxds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign mem_re    = cmd.rd_x || cmd.rd_e;
    assign mem_raddr = cmd.rd_x ? x_reg[AW-1:0] : ex_reg;
    assign mem_we    = cmd.wr_acc || (cmd.out_load && stat.e_ylast);
    assign mem_waddr = cmd.wr_acc ? x_reg[AW-1:0] : ex_reg;
    assign mem_wdata = cmd.wr_acc ? acc_sums : '0;
    assign cnt_prod  = wx_reg * hy_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sum_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_reg  <= sum_mem[mem_raddr];
            rdv_reg <= vld_reg[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg   <= SW'(bxds_pkg::MAX_SRC_DIM);
            sh_reg   <= SW'(bxds_pkg::MAX_SRC_DIM);
            dw_reg   <= DW'(bxds_pkg::MAX_DST_DIM);
            dh_reg   <= DW'(bxds_pkg::MAX_DST_DIM);
            sc_reg   <= '0;
            sr_reg   <= '0;
            vld_reg  <= '0;
            yany_reg <= 1'b0;
            xany_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                sc_reg  <= '0;
                sr_reg  <= '0;
                vld_reg <= '0;
                case (bxds_pkg::cfg_reg_t'(cfg_index))
                    bxds_pkg::REG_SRC_WIDTH:  sw_reg <= cfg_wdata[SW-1:0];
                    bxds_pkg::REG_SRC_HEIGHT: sh_reg <= cfg_wdata[SW-1:0];
                    bxds_pkg::REG_DST_WIDTH:  dw_reg <= cfg_wdata[DW-1:0];
                    bxds_pkg::REG_DST_HEIGHT: dh_reg <= cfg_wdata[DW-1:0];
                    default: begin
                        sw_reg <= sw_reg;
                    end
                endcase
            end else begin
                if (mem_we) begin
                    vld_reg[mem_waddr] <= 1'b1;
                end
                if (cmd.pos_adv) begin
                    if (sc_p1 >= sw_reg) begin
                        sc_reg <= '0;
                        if (sr_p1 >= sh_reg) begin
                            sr_reg <= '0;
                        end else begin
                            sr_reg <= sr_p1[bxds_pkg::POS_W-1:0];
                        end
                    end else begin
                        sc_reg <= sc_p1[bxds_pkg::POS_W-1:0];
                    end
                end
            end
            if (cmd.accept) begin
                xany_reg <= 1'b0;
                if (sc_reg == '0) begin
                    yany_reg <= 1'b0;
                end
            end
            if (cmd.y_adv) begin
                yany_reg <= 1'b1;
            end
            if (cmd.x_adv) begin
                xany_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            px_reg <= s_tdata;
        end
        if (cmd.y_init) begin
            y_reg    <= '0;
            ylo_reg  <= '0;
            ynum_reg <= bxds_pkg::NUM_W'(sh_reg);
        end
        if (cmd.y_hload) begin
            yhraw_reg <= div_quo[0];
        end
        if (cmd.y_adv) begin
            if (!yany_reg) begin
                yf_reg <= y_reg[CW-1:0];
                hy_reg <= yhi - ylo_reg;
            end
            yl_reg   <= y_reg[CW-1:0];
            y_reg    <= y_reg + DW'(1);
            ylo_reg  <= yhraw_reg;
            ynum_reg <= ynum_reg + bxds_pkg::NUM_W'(sh_reg);
        end
        if (cmd.x_init) begin
            x_reg    <= '0;
            xlo_reg  <= '0;
            xnum_reg <= bxds_pkg::NUM_W'(sw_reg);
        end
        if (cmd.x_hload) begin
            xhraw_reg <= div_quo[0];
        end
        if (cmd.x_adv) begin
            if (!xany_reg) begin
                xf_reg <= x_reg[CW-1:0];
                wx_reg <= xhi - xlo_reg;
            end
            xl_reg   <= x_reg[CW-1:0];
            x_reg    <= x_reg + DW'(1);
            xlo_reg  <= xhraw_reg;
            xnum_reg <= xnum_reg + bxds_pkg::NUM_W'(sw_reg);
        end
        if (cmd.emit_init) begin
            cnt_reg <= cnt_prod[bxds_pkg::CNT_W-1:0];
            ex_reg  <= xf_reg;
            ey_reg  <= yf_reg;
        end
        if (cmd.e_next_x) begin
            ex_reg <= ex_reg + CW'(1);
        end
        if (cmd.e_next_y) begin
            ey_reg <= ey_reg + CW'(1);
            ex_reg <= xf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load || cmd.err_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {avg_pix, ey_reg, ex_reg};
            m_last_reg <= stat.e_xlast && stat.e_ylast;
            m_err_reg  <= 1'b0;
        end else if (cmd.err_load) begin
            m_data_reg <= '0;
            m_last_reg <= 1'b1;
            m_err_reg  <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_err_reg;

    always_comb begin
        stat          = '0;
        stat.sc_zero  = (sc_reg == '0);
        stat.sr_zero  = (sr_reg == '0);
        stat.cfg_bad  = cfg_bad;
        stat.y_in     = (y_reg < dh_reg) && (ylo_reg <= SW'(sr_reg));
        stat.y_done   = (yhi == sr_p1);
        stat.x_in     = (x_reg < dw_reg) && (xlo_reg <= SW'(sc_reg));
        stat.x_done   = (xhi == sc_p1);
        stat.emit_go  = xany_reg && yany_reg;
        stat.e_xlast  = (ex_reg == xl_reg);
        stat.e_ylast  = (ey_reg == yl_reg);
        stat.div_done = div_done;
        stat.out_free = !m_valid_reg || m_tready;
    end

endmodule

`default_nettype wire

// ===== rtl/core/box_downsample_rgba8.sv =====
// Top level of the RGBA8 box-filter image downscaler.
`default_nettype none

// Source pixels enter in raster order; each output pixel is the per-channel truncated mean
// of its source window and leaves, with its column and row, on the transfer of the source
// pixel that completes the window. A new pixel is taken only after the last one is fully
// handled. The shared one-bit-per-cycle divider finds the column window bounds, the row
// window bounds at the first pixel of each source row and the averages of each result;
// each result may also wait on m_tready. Any register write restarts the frame. An
// unusable configuration answers each pixel with one result flagged in m_tuser.
module box_downsample_rgba8 (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [bxds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bxds_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [bxds_pkg::PIX_W-1:0]          s_tdata,  // in_pixel
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [bxds_pkg::OUT_TDATA_W-1:0]         m_tdata,  // dst_x, dst_y, out_pixel
    output logic                                     m_tlast,
    output logic                                     m_tuser   // config_error
);

    bxds_pkg::bxds_cmd_t  cmd;
    bxds_pkg::bxds_stat_t stat;

    bxds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bxds_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/core/bxds_checker.sv =====
// Port-level checks on the downscaler result stream, bound to the top level.
`default_nettype none

module bxds_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [bxds_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input wire logic                              m_tlast,
    input wire logic                              m_tuser
);

    a_err_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("error result without tlast");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result carries data");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind box_downsample_rgba8 bxds_checker u_bxds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
